FILE: src/ecd_pkg.sv
`timescale 1ns / 1ps

package ecd_pkg;

  // Offset that lifts floor(seconds / 128) into a non-negative range:
  // 24856 whole days of 675 units each.
  localparam logic [25:0] DAY_OFS      = 26'd16777800;
  // Reciprocal of 675 scaled by 2^26, rounded down.
  localparam logic [16:0] RCP_675      = 17'd99420;
  localparam logic [25:0] UNITS_PER_DAY = 26'd675;

  // Day number bias: shifts the biased day number onto whole four-year periods.
  localparam logic [15:0] QUAD_BIAS    = 16'd1442;
  // Bias that aligns the biased day number with weekday 0 (Sunday).
  localparam logic [15:0] WDAY_BIAS    = 16'd5;
  localparam logic [11:0] DAYS_PER_QUAD = 12'd1461;
  localparam logic [5:0]  RCP_1461     = 6'd44;     // 2^16 / 1461
  localparam logic [13:0] RCP_7        = 14'd9362;  // 2^16 / 7
  localparam logic [5:0]  RCP_3600     = 6'd36;     // 2^17 / 3600
  localparam logic [6:0]  RCP_60       = 7'd68;     // 2^12 / 60
  localparam logic [12:0] SECS_PER_HOUR = 13'd3600;
  localparam logic [6:0]  SECS_PER_MIN = 7'd60;
  localparam logic [3:0]  DAYS_PER_WEEK = 4'd7;

  // First year of the four-year period at biased period index zero.
  localparam logic [10:0] YEAR_BASE    = 11'd1898;
  // Day offsets of the second, third and fourth year in a period.
  localparam logic [10:0] YEAR1_START  = 11'd365;
  localparam logic [10:0] YEAR2_START  = 11'd730;
  localparam logic [10:0] YEAR3_START  = 11'd1096;
  localparam logic [1:0]  LEAP_SLOT    = 2'd2;

  // Day number split into day and second of day
  typedef struct packed {
    logic [15:0] dnum;
    logic [16:0] sod;
  } ecd_split_t;

  // Calendar fields of one result
  typedef struct packed {
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } ecd_date_t;

  // Days before the first of the month, non-leap year; index 0 is January
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] val;
    case (idx)
      4'd0:    val = 9'd0;
      4'd1:    val = 9'd31;
      4'd2:    val = 9'd59;
      4'd3:    val = 9'd90;
      4'd4:    val = 9'd120;
      4'd5:    val = 9'd151;
      4'd6:    val = 9'd181;
      4'd7:    val = 9'd212;
      4'd8:    val = 9'd243;
      4'd9:    val = 9'd273;
      4'd10:   val = 9'd304;
      4'd11:   val = 9'd334;
      4'd12:   val = 9'd365;
      default: val = 9'd0;
    endcase
    return val;
  endfunction

endpackage

FILE: src/ecd_daysplit.sv
`timescale 1ns / 1ps

module ecd_daysplit import ecd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_ready,
  input  logic [31:0] up_secs,
  output logic        dn_valid,
  input  logic        dn_ready,
  output ecd_split_t  dn_data
);

  localparam int Stages = 4;

  logic [Stages-1:0] v_r;
  logic [Stages-1:0] adv;

  logic [25:0] u1_r, u2_r;
  logic [6:0]  b1_r, b2_r, b3_r;
  logic [15:0] qe2_r, qe3_r;
  logic [10:0] r03_r;
  ecd_split_t  out_r;

  logic [25:0] u_nxt;
  logic [42:0] prod;
  logic [15:0] qe_nxt;
  logic [10:0] r0_nxt;
  logic [10:0] r_fix;
  logic [15:0] dnum_nxt;

  // Advance a stage when it is empty or the next one moves
  always_comb begin
    adv[Stages-1] = !v_r[Stages-1] || dn_ready;
    for (int i = Stages - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  assign up_ready = adv[0];
  assign dn_valid = v_r[Stages-1];
  assign dn_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= up_valid;
      end
      for (int i = 1; i < Stages; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Stage 1: floor(secs / 128), biased non-negative; keep low seven bits
  assign u_nxt = {up_secs[31], up_secs[31:7]} + DAY_OFS;

  // Stage 2: estimate quotient by 675 with a reciprocal
  assign prod   = 43'(u1_r) * 43'(RCP_675);
  assign qe_nxt = prod[41:26];

  // Stage 3: remainder of the estimate, below twice the divisor
  assign r0_nxt = 11'(u2_r - 26'(qe2_r) * UNITS_PER_DAY);

  // Stage 4: correct the estimate by one when needed
  always_comb begin
    if (r03_r >= 11'(UNITS_PER_DAY)) begin
      r_fix    = r03_r - 11'(UNITS_PER_DAY);
      dnum_nxt = qe3_r + 16'd1;
    end else begin
      r_fix    = r03_r;
      dnum_nxt = qe3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      u1_r <= u_nxt;
      b1_r <= up_secs[6:0];
    end
    if (adv[1]) begin
      u2_r  <= u1_r;
      b2_r  <= b1_r;
      qe2_r <= qe_nxt;
    end
    if (adv[2]) begin
      b3_r  <= b2_r;
      qe3_r <= qe2_r;
      r03_r <= r0_nxt;
    end
    if (adv[3]) begin
      out_r.dnum <= dnum_nxt;
      out_r.sod  <= {r_fix[9:0], b3_r};
    end
  end

endmodule

FILE: src/ecd_fields.sv
`timescale 1ns / 1ps

module ecd_fields import ecd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  output logic       up_ready,
  input  ecd_split_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output ecd_date_t  dn_data
);

  localparam int Stages = 5;

  logic [Stages-1:0] v_r;
  logic [Stages-1:0] adv;

  // Stage 1 registers
  logic [15:0] e1_r, w1_r;
  logic [16:0] sod1_r;
  logic [5:0]  qq1_r;
  logic [12:0] wq1_r;
  logic [4:0]  hq1_r;
  // Stage 2 registers
  logic [4:0]  hour2_r;
  logic [11:0] ms2_r;
  logic [5:0]  qd2_r;
  logic [10:0] dq2_r;
  logic [2:0]  wd2_r;
  // Stage 3 registers
  logic [4:0]  hour3_r;
  logic [11:0] ms3_r;
  logic [5:0]  mq3_r;
  logic [2:0]  wd3_r;
  logic [10:0] year3_r;
  logic [1:0]  yi3_r;
  logic [8:0]  dy3_r;
  // Stage 4 registers
  logic [10:0] year4_r;
  logic [3:0]  mon4_r;
  logic [8:0]  dy4_r;
  logic        leap4_r;
  logic [4:0]  hour4_r;
  logic [5:0]  min4_r;
  logic [5:0]  sec4_r;
  logic [2:0]  wd4_r;
  ecd_date_t   out_r;

  logic [15:0] e_nxt, w_nxt;
  logic [21:0] qq_prod, hq_prod;
  logic [28:0] wq_prod;
  logic [12:0] hr0;
  logic [11:0] d0;
  logic [3:0]  w0;
  logic [4:0]  hour_nxt;
  logic [11:0] ms_nxt;
  logic [5:0]  qd_nxt;
  logic [10:0] dq_nxt;
  logic [2:0]  wd_nxt;
  logic [17:0] mq_prod;
  logic [1:0]  yi_nxt;
  logic [10:0] dy_wide;
  logic [6:0]  s0;
  logic [5:0]  min_nxt, sec_nxt;
  logic        leap;
  logic [8:0]  bound;
  logic [3:0]  mon_nxt;
  logic [8:0]  first_day;
  logic [8:0]  mday;

  // Advance a stage when it is empty or the next one moves
  always_comb begin
    adv[Stages-1] = !v_r[Stages-1] || dn_ready;
    for (int i = Stages - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  assign up_ready = adv[0];
  assign dn_valid = v_r[Stages-1];
  assign dn_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= up_valid;
      end
      for (int i = 1; i < Stages; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Stage 1: bias day number, estimate period, weekday and hour quotients
  assign e_nxt   = up_data.dnum + QUAD_BIAS;
  assign w_nxt   = up_data.dnum + WDAY_BIAS;
  assign qq_prod = 22'(e_nxt) * 22'(RCP_1461);
  assign wq_prod = 29'(w_nxt) * 29'(RCP_7);
  assign hq_prod = 22'(up_data.sod) * 22'(RCP_3600);

  // Stage 2: correct each quotient by at most one
  assign hr0 = 13'(sod1_r - 17'(hq1_r) * 17'(SECS_PER_HOUR));
  assign d0  = 12'(e1_r - 16'(qq1_r) * 16'(DAYS_PER_QUAD));
  assign w0  = 4'(w1_r - 16'(wq1_r) * 16'(DAYS_PER_WEEK));

  always_comb begin
    if (hr0 >= SECS_PER_HOUR) begin
      ms_nxt   = 12'(hr0 - SECS_PER_HOUR);
      hour_nxt = hq1_r + 5'd1;
    end else begin
      ms_nxt   = hr0[11:0];
      hour_nxt = hq1_r;
    end
    if (d0 >= DAYS_PER_QUAD) begin
      dq_nxt = 11'(d0 - DAYS_PER_QUAD);
      qd_nxt = qq1_r + 6'd1;
    end else begin
      dq_nxt = d0[10:0];
      qd_nxt = qq1_r;
    end
    if (w0 >= DAYS_PER_WEEK) begin
      wd_nxt = 3'(w0 - DAYS_PER_WEEK);
    end else begin
      wd_nxt = w0[2:0];
    end
  end

  // Stage 3: minute estimate, step through the years of the period
  assign mq_prod = 18'(ms2_r) * 18'(RCP_60);

  always_comb begin
    if (dq2_r < YEAR1_START) begin
      yi_nxt  = 2'd0;
      dy_wide = dq2_r;
    end else if (dq2_r < YEAR2_START) begin
      yi_nxt  = 2'd1;
      dy_wide = dq2_r - YEAR1_START;
    end else if (dq2_r < YEAR3_START) begin
      yi_nxt  = 2'd2;
      dy_wide = dq2_r - YEAR2_START;
    end else begin
      yi_nxt  = 2'd3;
      dy_wide = dq2_r - YEAR3_START;
    end
  end

  // Stage 4: correct minute, find the month from the cumulative table
  assign s0   = 7'(ms3_r - 12'(mq3_r) * 12'(SECS_PER_MIN));
  assign leap = (yi3_r == LEAP_SLOT);

  always_comb begin
    if (s0 >= SECS_PER_MIN) begin
      sec_nxt = 6'(s0 - SECS_PER_MIN);
      min_nxt = mq3_r + 6'd1;
    end else begin
      sec_nxt = s0[5:0];
      min_nxt = mq3_r;
    end
  end

  always_comb begin
    mon_nxt = 4'd1;
    bound   = '0;
    for (int i = 1; i < 12; i++) begin
      bound = month_start(4'(i)) + {8'd0, leap && (i >= 2)};
      if (dy3_r >= bound) begin
        mon_nxt = 4'(i + 1);
      end
    end
  end

  // Stage 5: day of month
  assign first_day = month_start(mon4_r - 4'd1) + {8'd0, leap4_r && (mon4_r >= 4'd3)};
  assign mday      = dy4_r + 9'd1 - first_day;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      e1_r   <= e_nxt;
      w1_r   <= w_nxt;
      sod1_r <= up_data.sod;
      qq1_r  <= qq_prod[21:16];
      wq1_r  <= wq_prod[28:16];
      hq1_r  <= hq_prod[21:17];
    end
    if (adv[1]) begin
      hour2_r <= hour_nxt;
      ms2_r   <= ms_nxt;
      qd2_r   <= qd_nxt;
      dq2_r   <= dq_nxt;
      wd2_r   <= wd_nxt;
    end
    if (adv[2]) begin
      hour3_r <= hour2_r;
      ms3_r   <= ms2_r;
      mq3_r   <= mq_prod[17:12];
      wd3_r   <= wd2_r;
      year3_r <= YEAR_BASE + {3'b000, qd2_r, yi_nxt};
      yi3_r   <= yi_nxt;
      dy3_r   <= dy_wide[8:0];
    end
    if (adv[3]) begin
      year4_r <= year3_r;
      mon4_r  <= mon_nxt;
      dy4_r   <= dy3_r;
      leap4_r <= leap;
      hour4_r <= hour3_r;
      min4_r  <= min_nxt;
      sec4_r  <= sec_nxt;
      wd4_r   <= wd3_r;
    end
    if (adv[4]) begin
      out_r.year    <= year4_r;
      out_r.month   <= mon4_r;
      out_r.day     <= mday[4:0];
      out_r.hour    <= hour4_r;
      out_r.minute  <= min4_r;
      out_r.second  <= sec4_r;
      out_r.weekday <= wd4_r;
    end
  end

endmodule

FILE: src/epoch_seconds_to_calendar_date_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                 Payload
// in_      input      in_valid / in_stall       in_seconds_count (signed 32)
// out_     output     out_valid / out_stall     out_year .. out_weekday
//
// Nine register stages: an item enters each cycle while in_stall is low; its
// result is registered through each stage in turn and offered from the last;
// the reciprocal multiplies set the stage cut.
// Reset (rst_n low, synchronous) clears the valid bits of all stages.
// A stage holds while the stage after it holds; empty stages still fill,
// so in_stall rises only when every stage holds a transaction.

module epoch_seconds_to_calendar_date_core import ecd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_seconds_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [2:0]  out_weekday
);

  logic       in_ready;
  logic       mid_valid;
  logic       mid_ready;
  ecd_split_t mid_data;
  ecd_date_t  date;

  // Split seconds into day number and second of day
  ecd_daysplit u_daysplit (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_secs  (in_seconds_count),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_data  (mid_data)
  );

  // Derive calendar and clock fields
  ecd_fields u_fields (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .up_data  (mid_data),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .dn_data  (date)
  );

  assign in_stall    = !in_ready;
  assign out_year    = date.year;
  assign out_month   = date.month;
  assign out_day     = date.day;
  assign out_hour    = date.hour;
  assign out_minute  = date.minute;
  assign out_second  = date.second;
  assign out_weekday = date.weekday;

endmodule
